### hdl/dehs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_pkg
// Types, register codes and drive control constants shared by the drive
// enable-and-hold sequencer.
// ----------------------------------------------------------------------------
package dehs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_CYCLES     = 3'd0,
        CFG_RUN_TIMEOUT     = 3'd1,
        CFG_DISABLE_TICKS   = 3'd2,
        CFG_OPERATION_MODE  = 3'd3,
        CFG_MIN_VALID_COUNT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_RUN     = 2'd0,
        PH_DISABLE = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OUT_PENDING       = 2'd0,
        OUT_COMPLETED     = 2'd1,
        OUT_NEVER_ENABLED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic        [31:0] hold_cycles;
        logic        [31:0] run_timeout;
        logic        [15:0] disable_ticks;
        logic signed [7:0]  operation_mode;
        logic        [15:0] min_valid_count;
    } t_cfg;

    typedef struct packed {
        logic               stop_request;
        logic               exchange_complete;
        logic        [15:0] wkc;
        logic signed [31:0] position_actual;
        logic        [15:0] statusword;
    } t_in_item;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_HOLD_CYCLES     = 32'd5000;
    localparam logic [31:0] RST_RUN_TIMEOUT     = 32'd30000;
    localparam logic [15:0] RST_DISABLE_TICKS   = 16'd300;
    localparam logic [7:0]  RST_OPERATION_MODE  = 8'd8;
    localparam logic [15:0] RST_MIN_VALID_COUNT = 16'd3;

    // Statusword decoding
    localparam logic [15:0] SW_STATE_MASK     = 16'h006f;
    localparam logic [15:0] SW_SOD_MASK       = 16'h004f;
    localparam logic [15:0] SW_FAULT          = 16'h0008;
    localparam logic [15:0] SW_SWITCH_ON_DIS  = 16'h0040;
    localparam logic [15:0] SW_READY          = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON    = 16'h0023;
    localparam logic [15:0] SW_OP_ENABLED     = 16'h0027;

    // Controlword commands
    localparam logic [15:0] CW_NONE           = 16'h0000;
    localparam logic [15:0] CW_FAULT_RESET    = 16'h0080;
    localparam logic [15:0] CW_SHUTDOWN       = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON      = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP      = 16'h000f;

    function automatic logic [15:0] ladder_cw(input logic [15:0] sw);
        logic [15:0] cw;
        if ((sw & SW_FAULT) != 16'h0000) begin
            cw = CW_FAULT_RESET;
        end else if ((sw & SW_SOD_MASK) == SW_SWITCH_ON_DIS) begin
            cw = CW_SHUTDOWN;
        end else if ((sw & SW_STATE_MASK) == SW_READY) begin
            cw = CW_SWITCH_ON;
        end else if (((sw & SW_STATE_MASK) == SW_SWITCHED_ON) ||
                     ((sw & SW_STATE_MASK) == SW_OP_ENABLED)) begin
            cw = CW_ENABLE_OP;
        end else begin
            cw = CW_SHUTDOWN;
        end
        return cw;
    endfunction

endpackage
`default_nettype wire

### hdl/dehs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_cfg_regs
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module dehs_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [dehs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dehs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output dehs_pkg::t_cfg                       o_cfg
);
    import dehs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_cycles     <= RST_HOLD_CYCLES;
            r_cfg.run_timeout     <= RST_RUN_TIMEOUT;
            r_cfg.disable_ticks   <= RST_DISABLE_TICKS;
            r_cfg.operation_mode  <= RST_OPERATION_MODE;
            r_cfg.min_valid_count <= RST_MIN_VALID_COUNT;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOLD_CYCLES:     r_cfg.hold_cycles     <= i_cfg_wdata;
                CFG_RUN_TIMEOUT:     r_cfg.run_timeout     <= i_cfg_wdata;
                CFG_DISABLE_TICKS:   r_cfg.disable_ticks   <= i_cfg_wdata[15:0];
                CFG_OPERATION_MODE:  r_cfg.operation_mode  <= i_cfg_wdata[7:0];
                CFG_MIN_VALID_COUNT: r_cfg.min_valid_count <= i_cfg_wdata[15:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hdl/dehs_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_in_stage
// Input register: captures one transaction and holds it until the
// sequencer stage takes it.
// ----------------------------------------------------------------------------
module dehs_in_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [dehs_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic [dehs_pkg::IN_USER_W-1:0] i_s_tuser,
    output logic                                o_valid,
    input  wire logic                           i_take,
    output dehs_pkg::t_in_item                  o_item
);
    import dehs_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign o_s_tready = !r_valid || i_take;
    assign w_load     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.statusword        <= i_s_tdata[15:0];
            r_item.position_actual   <= i_s_tdata[47:16];
            r_item.wkc               <= i_s_tdata[63:48];
            r_item.exchange_complete <= i_s_tuser[0];
            r_item.stop_request      <= i_s_tuser[1];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

### hdl/dehs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_seq
// Sequencer state, per-tick next-state logic and the result register.
// ----------------------------------------------------------------------------
module dehs_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dehs_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_in_valid,
    input  wire dehs_pkg::t_in_item              i_item,
    output logic                                 o_take,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [dehs_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import dehs_pkg::*;

    t_phase       r_phase,      n_phase;
    logic         r_latched,    n_latched;
    logic         r_was_en,     n_was_en;
    logic [31:0]  r_held,       n_held;
    logic [31:0]  r_run_ticks,  n_run_ticks;
    logic [31:0]  r_en_ticks,   n_en_ticks;
    logic [15:0]  r_dis_count,  n_dis_count;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        w_is_enabled;
    logic        w_stop;
    logic [15:0] w_cw;
    t_outcome    w_outcome;

    assign o_take       = i_in_valid && (!r_out_valid || i_m_tready);
    assign w_is_enabled = (i_item.statusword & SW_STATE_MASK) == SW_OP_ENABLED;
    assign w_stop       = i_item.stop_request;

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_latched   = r_latched;
        n_was_en    = r_was_en;
        n_held      = r_held;
        n_run_ticks = r_run_ticks;
        n_en_ticks  = r_en_ticks;
        n_dis_count = r_dis_count;
        case (r_phase)
            PH_RUN: begin
                if (w_stop) begin
                    n_phase = PH_DONE;
                end else begin
                    if (!r_latched && i_item.exchange_complete &&
                        (i_item.wkc >= i_cfg.min_valid_count)) begin
                        n_latched = 1'b1;
                        n_held    = i_item.position_actual;
                    end
                    if (n_latched && w_is_enabled) begin
                        n_was_en = 1'b1;
                        if (r_en_ticks != '1) begin
                            n_en_ticks = r_en_ticks + 32'd1;
                        end
                    end
                    if (n_was_en && (n_en_ticks >= i_cfg.hold_cycles)) begin
                        n_dis_count = '0;
                        n_phase     = (i_cfg.disable_ticks == '0) ? PH_DONE : PH_DISABLE;
                    end else begin
                        if (r_run_ticks != '1) begin
                            n_run_ticks = r_run_ticks + 32'd1;
                        end
                        if (n_run_ticks >= i_cfg.run_timeout) begin
                            n_dis_count = '0;
                            n_phase     = (i_cfg.disable_ticks == '0) ? PH_DONE : PH_DISABLE;
                        end
                    end
                end
            end
            PH_DISABLE: begin
                if (w_stop) begin
                    n_phase = PH_DONE;
                end else begin
                    if (r_dis_count != '1) begin
                        n_dis_count = r_dis_count + 16'd1;
                    end
                    if (n_dis_count >= i_cfg.disable_ticks) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Result fields
    always_comb begin
        w_cw = CW_NONE;
        if ((r_phase == PH_RUN) && !w_stop && n_latched) begin
            w_cw = w_is_enabled ? CW_ENABLE_OP : ladder_cw(i_item.statusword);
        end
        if (n_phase == PH_DONE) begin
            w_outcome = n_was_en ? OUT_COMPLETED : OUT_NEVER_ENABLED;
        end else begin
            w_outcome = OUT_PENDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RUN;
            r_latched   <= 1'b0;
            r_was_en    <= 1'b0;
            r_held      <= '0;
            r_run_ticks <= '0;
            r_en_ticks  <= '0;
            r_dis_count <= '0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_latched   <= n_latched;
            r_was_en    <= n_was_en;
            r_held      <= n_held;
            r_run_ticks <= n_run_ticks;
            r_en_ticks  <= n_en_ticks;
            r_dis_count <= n_dis_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_data <= {4'b0000, w_outcome, n_phase, n_held,
                           i_cfg.operation_mode, w_cw};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

### hdl/drive_enable_hold_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drive_enable_hold_sequencer_core
// Drive enable-and-hold sequencer: one control tick in, one command out.
//
// Each input transaction carries one tick of drive feedback; each output
// transaction carries the controlword, mode, hold position, phase and
// outcome for that tick. On the first tick with valid process data the
// position is latched, then the controlword walks the enable ladder, holds
// while the drive is enabled, and moves through a zero-controlword disable
// phase to finished. A stop request finishes at once.
// Between input acceptance and output valid lie the input register and then
// the result register. Throughput is one transaction per cycle while the
// receiver does not stall, set by the combinational next-state logic
// between the two registers. When the receiver stalls, the result register
// holds and the input register still takes one more transaction before
// tready drops. Synchronous active-low reset clears the sequencer state to
// the run phase and loads the configuration defaults; both channels come
// out empty. Configuration writes take effect on the next cycle, and
// they are to be made while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module drive_enable_hold_sequencer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [dehs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dehs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] statusword, [47:16] position_actual, [63:48] wkc
    input  wire logic [dehs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] exchange_complete, [1] stop_request
    input  wire logic [dehs_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [15:0] controlword, [23:16] mode_out, [55:24] target_position,
    // [57:56] phase, [59:58] outcome, [63:60] zero
    output logic [dehs_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import dehs_pkg::*;

    t_cfg     w_cfg;
    t_in_item w_item;
    logic     w_in_valid;
    logic     w_take;

    dehs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    dehs_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_valid    (w_in_valid),
        .i_take     (w_take),
        .o_item     (w_item)
    );

    dehs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (w_in_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

### hdl/dehs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_checker
// Port-level checks for the drive enable-and-hold sequencer.
// ----------------------------------------------------------------------------
module dehs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_wr_en,
    input wire logic [2:0]  i_cfg_index,
    input wire logic [31:0] i_cfg_wdata,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [63:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata
);
    import dehs_pkg::*;

    // output is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // phase only takes the defined codes
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[57:56] == PH_RUN) ||
                             (o_m_axis_tdata[57:56] == PH_DISABLE) ||
                             (o_m_axis_tdata[57:56] == PH_DONE)))
        else $error("phase out of range");

    // outcome is settled exactly when finished
    a_outcome_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[57:56] == PH_DONE) ==
             (o_m_axis_tdata[59:58] != OUT_PENDING)))
        else $error("outcome does not match phase");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind drive_enable_hold_sequencer_core dehs_checker u_dehs_checker (.*);
`default_nettype wire
